[sv/segment_ellipse_intersect_top_assert.svh]
// assertion macros for the segment/ellipse intersection block
`ifndef SEGMENT_ELLIPSE_INTERSECT_TOP_ASSERT_SVH
`define SEGMENT_ELLIPSE_INTERSECT_TOP_ASSERT_SVH

// same-cycle implication
`define SEI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sei assertion failed");

// next-cycle implication
`define SEI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sei assertion failed");

`endif

[sv/sei_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sei_pkg
// shared types and constants of the segment/ellipse intersection pipeline
// ----------------------------------------------------------------------------
package sei_pkg;

    // headroom above the product widths for the wide coefficient sums
    localparam int GUARD_BITS = 3;

    // control bits that travel with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic rzero;
    } t_stage_ctl;

endpackage

[sv/sei_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sei_in_if
// segment and ellipse query channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface sei_in_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic        [COORD_BITS-2:0] radius_x;
    logic        [COORD_BITS-2:0] radius_y;

    modport source (
        output valid, start_x, start_y, end_x, end_y, center_x, center_y,
               radius_x, radius_y,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, end_x, end_y, center_x, center_y,
               radius_x, radius_y,
        output ready
    );
endinterface

[sv/sei_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sei_out_if
// hit result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface sei_out_if ();
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

[sv/sei_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sei_prep
// stages 1-2: offsets, radius squares, then all coordinate products
// ----------------------------------------------------------------------------
module sei_prep #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COORD_BITS-1:0]  i_start_x,
    input  logic signed [COORD_BITS-1:0]  i_start_y,
    input  logic signed [COORD_BITS-1:0]  i_end_x,
    input  logic signed [COORD_BITS-1:0]  i_end_y,
    input  logic signed [COORD_BITS-1:0]  i_center_x,
    input  logic signed [COORD_BITS-1:0]  i_center_y,
    input  logic        [COORD_BITS-2:0]  i_radius_x,
    input  logic        [COORD_BITS-2:0]  i_radius_y,
    output sei_pkg::t_stage_ctl           o_ctl,
    output logic signed [2*COORD_BITS+1:0] o_dx2,
    output logic signed [2*COORD_BITS+1:0] o_dy2,
    output logic signed [2*COORD_BITS+1:0] o_px2,
    output logic signed [2*COORD_BITS+1:0] o_py2,
    output logic signed [2*COORD_BITS+1:0] o_pxdx,
    output logic signed [2*COORD_BITS+1:0] o_pydy,
    output logic signed [2*COORD_BITS+1:0] o_pxdy,
    output logic signed [2*COORD_BITS+1:0] o_pydx,
    output logic        [2*COORD_BITS-3:0] o_rx2,
    output logic        [2*COORD_BITS-3:0] o_ry2,
    output logic        [4*COORD_BITS-5:0] o_rr
);
    import sei_pkg::*;

    localparam int D  = COORD_BITS + 1;
    localparam int P  = 2 * D;
    localparam int RS = 2 * (COORD_BITS - 1);

    // stage 1
    t_stage_ctl          r_ctl1;
    logic signed [D-1:0] r_px, r_py, r_dx, r_dy;
    logic [RS-1:0]       r_rx2a, r_ry2a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else if (i_en) begin
            r_ctl1.valid <= i_valid;
            r_ctl1.rzero <= (i_radius_x == '0) || (i_radius_y == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px   <= D'(i_start_x) - D'(i_center_x);
            r_py   <= D'(i_start_y) - D'(i_center_y);
            r_dx   <= D'(i_end_x) - D'(i_start_x);
            r_dy   <= D'(i_end_y) - D'(i_start_y);
            r_rx2a <= RS'(i_radius_x * i_radius_x);
            r_ry2a <= RS'(i_radius_y * i_radius_y);
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_dx2  <= P'(r_dx * r_dx);
            o_dy2  <= P'(r_dy * r_dy);
            o_px2  <= P'(r_px * r_px);
            o_py2  <= P'(r_py * r_py);
            o_pxdx <= P'(r_px * r_dx);
            o_pydy <= P'(r_py * r_dy);
            o_pxdy <= P'(r_px * r_dy);
            o_pydx <= P'(r_py * r_dx);
            o_rx2  <= r_rx2a;
            o_ry2  <= r_ry2a;
            o_rr   <= (2*RS)'(r_rx2a * r_ry2a);
        end
    end
endmodule

[sv/sei_coef.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sei_coef
// stages 3-4: radius-weighted terms, then coefficients a, h = b/2, c and
// the squared cross product
// ----------------------------------------------------------------------------
module sei_coef #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  sei_pkg::t_stage_ctl            i_ctl,
    input  logic signed [2*COORD_BITS+1:0] i_dx2,
    input  logic signed [2*COORD_BITS+1:0] i_dy2,
    input  logic signed [2*COORD_BITS+1:0] i_px2,
    input  logic signed [2*COORD_BITS+1:0] i_py2,
    input  logic signed [2*COORD_BITS+1:0] i_pxdx,
    input  logic signed [2*COORD_BITS+1:0] i_pydy,
    input  logic signed [2*COORD_BITS+1:0] i_pxdy,
    input  logic signed [2*COORD_BITS+1:0] i_pydx,
    input  logic        [2*COORD_BITS-3:0] i_rx2,
    input  logic        [2*COORD_BITS-3:0] i_ry2,
    input  logic        [4*COORD_BITS-5:0] i_rr,
    output sei_pkg::t_stage_ctl            o_ctl,
    output logic signed [4*COORD_BITS+sei_pkg::GUARD_BITS-1:0] o_a,
    output logic signed [4*COORD_BITS+sei_pkg::GUARD_BITS-1:0] o_h,
    output logic signed [4*COORD_BITS+sei_pkg::GUARD_BITS-1:0] o_c,
    output logic signed [4*COORD_BITS+sei_pkg::GUARD_BITS-1:0] o_crsq
);
    import sei_pkg::*;

    localparam int D  = COORD_BITS + 1;
    localparam int P  = 2 * D;
    localparam int RS = 2 * (COORD_BITS - 1);
    localparam int W  = P + RS + GUARD_BITS;

    // stage 3
    t_stage_ctl          r_ctl3;
    logic signed [W-1:0] r_ry2dx2, r_rx2dy2, r_ry2px2, r_rx2py2, r_ry2pxdx, r_rx2pydy;
    logic signed [P:0]   r_cross;
    logic [2*RS-1:0]     r_rr;

    logic signed [RS:0]  w_rx2s, w_ry2s;
    logic signed [P:0]   w_cross_neg;
    logic [P-2:0]        w_cross_abs;

    assign w_rx2s = $signed({1'b0, i_rx2});
    assign w_ry2s = $signed({1'b0, i_ry2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_ctl3 <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ry2dx2  <= W'(w_ry2s * i_dx2);
            r_rx2dy2  <= W'(w_rx2s * i_dy2);
            r_ry2px2  <= W'(w_ry2s * i_px2);
            r_rx2py2  <= W'(w_rx2s * i_py2);
            r_ry2pxdx <= W'(w_ry2s * i_pxdx);
            r_rx2pydy <= W'(w_rx2s * i_pydy);
            r_cross   <= (P+1)'(i_pxdy) - (P+1)'(i_pydx);
            r_rr      <= i_rr;
        end
    end

    // |cross| stays below 2^(P-1)
    assign w_cross_neg = -r_cross;
    assign w_cross_abs = r_cross[P] ? w_cross_neg[P-2:0] : r_cross[P-2:0];

    // stage 4
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= r_ctl3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_a    <= r_ry2dx2 + r_rx2dy2;
            o_h    <= r_ry2pxdx + r_rx2pydy;
            o_c    <= r_ry2px2 + r_rx2py2 - $signed(W'(r_rr));
            o_crsq <= $signed(W'(w_cross_abs * w_cross_abs));
        end
    end
endmodule

[sv/sei_decide.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sei_decide
// stage 5: root-in-[0,1] decision and the output register
// ----------------------------------------------------------------------------
module sei_decide #(
    parameter int COORD_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  sei_pkg::t_stage_ctl i_ctl,
    input  logic signed [4*COORD_BITS+sei_pkg::GUARD_BITS-1:0] i_a,
    input  logic signed [4*COORD_BITS+sei_pkg::GUARD_BITS-1:0] i_h,
    input  logic signed [4*COORD_BITS+sei_pkg::GUARD_BITS-1:0] i_c,
    input  logic signed [4*COORD_BITS+sei_pkg::GUARD_BITS-1:0] i_crsq,
    output logic                o_valid,
    output logic                o_hit
);
    import sei_pkg::*;

    localparam int W = 4 * COORD_BITS + GUARD_BITS;

    logic signed [W-1:0] w_f1, w_neg_h;
    logic                w_c_le0, w_c_ge0, w_f1_le0, w_f1_ge0;
    logic                w_straddle, w_tangent, w_hit;

    assign w_f1    = i_a + (i_h <<< 1) + i_c;
    assign w_neg_h = -i_h;

    assign w_c_le0  = i_c[W-1] || (i_c == '0);
    assign w_c_ge0  = !i_c[W-1];
    assign w_f1_le0 = w_f1[W-1] || (w_f1 == '0);
    assign w_f1_ge0 = !w_f1[W-1];

    // f changes sign or touches zero at an endpoint
    assign w_straddle = (w_c_le0 && w_f1_ge0) || (w_c_ge0 && w_f1_le0);

    // both ends outside: vertex inside (0,1) and discriminant >= 0,
    // where b^2 - 4ac >= 0 reduces to a >= cross^2
    assign w_tangent = !w_c_le0 && !w_f1_le0 && i_h[W-1]
                       && (w_neg_h < i_a) && (i_a >= i_crsq);

    assign w_hit = !i_ctl.rzero && (i_a != '0) && (w_straddle || w_tangent);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit <= w_hit;
        end
    end
endmodule

[sv/segment_ellipse_intersect_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_ellipse_intersect_top
// segment versus axis-aligned ellipse boundary test, five-stage pipeline
// ----------------------------------------------------------------------------
// usage:
//   i_seg carries one query per transfer: segment endpoints, ellipse center
//   and the two semi-axes. o_res returns one hit bit per query, in order.
//   hit is set when the segment crosses or touches the ellipse boundary; a
//   zero-length segment or a zero semi-axis gives no hit.
//   throughput: one query per cycle when the receiver does not stall, through
//   the five register stages (offsets, coordinate products, weighted terms,
//   coefficients, decision).
//   reset clears every stage valid bit; the pipeline comes up empty and
//   ready. when the receiver stalls, all stages hold together and
//   i_seg.ready drops in the same cycle, so nothing is dropped or repeated;
//   a bubble at the output is filled while the receiver waits.
// ----------------------------------------------------------------------------
`include "segment_ellipse_intersect_top_assert.svh"

module segment_ellipse_intersect_top #(
    parameter int COORD_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sei_in_if.sink   i_seg,
    sei_out_if.source o_res
);
    import sei_pkg::*;

    localparam int D  = COORD_BITS + 1;
    localparam int P  = 2 * D;
    localparam int RS = 2 * (COORD_BITS - 1);
    localparam int W  = P + RS + GUARD_BITS;

    logic                w_en;
    logic                w_out_vld, w_out_hit;
    t_stage_ctl          w_s2_ctl, w_s4_ctl;
    logic signed [P-1:0] w_dx2, w_dy2, w_px2, w_py2, w_pxdx, w_pydy, w_pxdy, w_pydx;
    logic [RS-1:0]       w_rx2, w_ry2;
    logic [2*RS-1:0]     w_rr;
    logic signed [W-1:0] w_a, w_h, w_c, w_crsq;
    logic [2:0]          w_vld;
    logic                w_s4_rzero;

    // whole pipeline advances unless a result is held at the output
    assign w_en        = !w_out_vld || o_res.ready;
    assign i_seg.ready = w_en;
    assign o_res.valid = w_out_vld;
    assign o_res.hit   = w_out_hit;

    sei_prep #(.COORD_BITS(COORD_BITS)) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_seg.valid),
        .i_start_x  (i_seg.start_x),
        .i_start_y  (i_seg.start_y),
        .i_end_x    (i_seg.end_x),
        .i_end_y    (i_seg.end_y),
        .i_center_x (i_seg.center_x),
        .i_center_y (i_seg.center_y),
        .i_radius_x (i_seg.radius_x),
        .i_radius_y (i_seg.radius_y),
        .o_ctl      (w_s2_ctl),
        .o_dx2      (w_dx2),
        .o_dy2      (w_dy2),
        .o_px2      (w_px2),
        .o_py2      (w_py2),
        .o_pxdx     (w_pxdx),
        .o_pydy     (w_pydy),
        .o_pxdy     (w_pxdy),
        .o_pydx     (w_pydx),
        .o_rx2      (w_rx2),
        .o_ry2      (w_ry2),
        .o_rr       (w_rr)
    );

    sei_coef #(.COORD_BITS(COORD_BITS)) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_s2_ctl),
        .i_dx2   (w_dx2),
        .i_dy2   (w_dy2),
        .i_px2   (w_px2),
        .i_py2   (w_py2),
        .i_pxdx  (w_pxdx),
        .i_pydy  (w_pydy),
        .i_pxdy  (w_pxdy),
        .i_pydx  (w_pydx),
        .i_rx2   (w_rx2),
        .i_ry2   (w_ry2),
        .i_rr    (w_rr),
        .o_ctl   (w_s4_ctl),
        .o_a     (w_a),
        .o_h     (w_h),
        .o_c     (w_c),
        .o_crsq  (w_crsq)
    );

    sei_decide #(.COORD_BITS(COORD_BITS)) u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_s4_ctl),
        .i_a     (w_a),
        .i_h     (w_h),
        .i_c     (w_c),
        .i_crsq  (w_crsq),
        .o_valid (w_out_vld),
        .o_hit   (w_out_hit)
    );

    assign w_vld      = {w_s2_ctl.valid, w_s4_ctl.valid, w_out_vld};
    assign w_s4_rzero = w_en && w_s4_ctl.valid && w_s4_ctl.rzero;

    // a stall freezes the valid bits of stages 2 and 4 and of the output
    `SEI_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_en, $stable(w_vld))
    // a zero semi-axis never reports a hit
    `SEI_ASSERT_NEXT(a_rzero_no_hit, i_clk, i_rst_n, w_s4_rzero, o_res.valid && !o_res.hit)
    // a held result blocks new queries
    `SEI_ASSERT_SAME(a_backpressure, i_clk, i_rst_n, o_res.valid && !o_res.ready, !i_seg.ready)
endmodule

[verif/segment_ellipse_intersect_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_ellipse_intersect_top_tb
// self-checking bench for the segment/ellipse boundary test pipeline
// ----------------------------------------------------------------------------
// directed queries cover extreme coordinates and radii, zero-length segments,
// segments wholly inside, endpoints on the boundary and tangent lines; random
// queries follow, mostly built near the ellipse so hits and misses both occur.
// each query is predicted with exact wide arithmetic and the hit bits are
// compared in order. idle and stall bursts on both channels, one long output
// stall that fills the pipeline, and one drain pause are included.
// ----------------------------------------------------------------------------
module segment_ellipse_intersect_top_tb;

    localparam int COORD_BITS = 16;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic signed [15:0] sx, sy, ex, ey, cx, cy;
        logic [14:0]        rx, ry;
    } t_query;

    logic i_clk;
    logic i_rst_n;

    sei_in_if #(.COORD_BITS(COORD_BITS)) seg_if ();
    sei_out_if res_if ();

    segment_ellipse_intersect_top #(.COORD_BITS(COORD_BITS)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_seg  (seg_if.sink),
        .o_res  (res_if.source)
    );

    logic hit_queue[$];
    int   mismatch_count = 0;
    int   hit_seen = 0;
    int   result_count = 0;
    int   cycle_count = 0;
    bit   idle_enable = 1;
    bit   hold_off = 0;
    int   hold_cycles = 0;
    int   ready_idle = 0;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // exact hit test on 256-bit signed values
    function automatic logic predict_hit(t_query q);
        logic signed [255:0] px, py, dx, dy, rx2, ry2, a, b, c, f1, nb, disc;
        logic                hit;
        px  = q.sx - q.cx;
        py  = q.sy - q.cy;
        dx  = q.ex - q.sx;
        dy  = q.ey - q.sy;
        rx2 = q.rx * q.rx;
        ry2 = q.ry * q.ry;
        hit = 0;
        if (q.rx != 0 && q.ry != 0) begin
            a = ry2 * dx * dx + rx2 * dy * dy;
            b = 2 * (ry2 * px * dx + rx2 * py * dy);
            c = ry2 * px * px + rx2 * py * py - rx2 * ry2;
            if (a != 0) begin
                f1 = a + b + c;
                if ((c <= 0 && f1 >= 0) || (c >= 0 && f1 <= 0)) begin
                    hit = 1;
                end else if (c > 0 && f1 > 0) begin
                    nb = -b;
                    if (nb > 0 && nb < a + a) begin
                        disc = b * b - 4 * a * c;
                        if (disc >= 0) hit = 1;
                    end
                end
            end
        end
        return hit;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // valid stays high after the transfer; whoever pauses the sender drops it
    task automatic send_query(t_query q);
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            seg_if.valid <= 0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        seg_if.valid    <= 1;
        seg_if.start_x  <= q.sx;
        seg_if.start_y  <= q.sy;
        seg_if.end_x    <= q.ex;
        seg_if.end_y    <= q.ey;
        seg_if.center_x <= q.cx;
        seg_if.center_y <= q.cy;
        seg_if.radius_x <= q.rx;
        seg_if.radius_y <= q.ry;
        do @(posedge i_clk); while (!seg_if.ready);
        hit_queue.push_back(predict_hit(q));
        @(negedge i_clk);
    endtask

    function automatic t_query make_query(int sx, int sy, int ex, int ey,
                                          int cx, int cy, int rx, int ry);
        t_query q;
        q.sx = 16'(sx); q.sy = 16'(sy); q.ex = 16'(ex); q.ey = 16'(ey);
        q.cx = 16'(cx); q.cy = 16'(cy); q.rx = 15'(rx); q.ry = 15'(ry);
        return q;
    endfunction

    function automatic int rand_coord();
        return $signed(16'($urandom()));
    endfunction

    // random point near the ellipse so that crossings and near misses show up
    function automatic int near(int c, int r);
        int v;
        v = c + $urandom_range(0, 6 * r) - 3 * r;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    task automatic test_directed();
        send_query(make_query(-32768, -32768, 32767, 32767, 0, 0, 32767, 32767));
        send_query(make_query(32767, -32768, -32768, 32767, -32768, 32767, 1, 1));
        send_query(make_query(5, 5, 5, 5, 5, 0, 5, 5));       // zero length on boundary
        send_query(make_query(0, 0, 0, 0, 0, 0, 10, 10));     // zero length inside
        send_query(make_query(-2, 0, 2, 0, 0, 0, 10, 20));    // wholly inside
        send_query(make_query(10, 0, 50, 0, 0, 0, 10, 20));   // endpoint on boundary
        send_query(make_query(0, 20, 0, 99, 0, 0, 10, 20));
        send_query(make_query(-50, 10, 50, 10, 0, 0, 10, 10)); // tangent
        send_query(make_query(-50, 11, 50, 11, 0, 0, 10, 10)); // just misses
        send_query(make_query(-50, 0, 50, 0, 0, 0, 10, 10));   // crosses twice
        send_query(make_query(-50, 0, -20, 0, 0, 0, 10, 10));  // line hits, segment not
        send_query(make_query(-32768, 0, 32767, 0, 0, 0, 32767, 1));
        send_query(make_query(0, -32768, 0, 32767, 100, 0, 1, 32767));
        send_query(make_query(32767, 32767, -32768, -32768, 32767, -32768, 16384, 21845));
        send_query(make_query(-1, -1, 1, 1, -1, -1, 1, 1));
        send_query(make_query(21845, -21846, -21846, 21845, 0, 0, 10922, 5461));
    endtask

    task automatic test_random(int count);
        t_query q;
        int     rx, ry, cx, cy;
        repeat (count) begin
            if ($urandom_range(0, 9) < 2) begin
                q = make_query(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                               rand_coord(), rand_coord(), $urandom_range(1, 32767),
                               $urandom_range(1, 32767));
            end else begin
                rx = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 32767);
                ry = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 32767);
                cx = rand_coord() / ($urandom_range(0, 1) ? 1 : 256);
                cy = rand_coord() / ($urandom_range(0, 1) ? 1 : 256);
                q = make_query(near(cx, rx), near(cy, ry), near(cx, rx), near(cy, ry),
                               cx, cy, rx, ry);
                if ($urandom_range(0, 19) == 0) begin
                    q.ex = q.sx;
                    q.ey = q.sy;
                end
            end
            send_query(q);
        end
    endtask

    task automatic test_output_stall();
        hold_cycles = 40;
        hold_off = 1;
        test_random(30);
    endtask

    task automatic test_drain_pause();
        seg_if.valid <= 0;
        while (hit_queue.size() != 0) @(negedge i_clk);
        test_random(20);
    endtask

    // long receiver hold-off counted here, along with random ready idles
    always @(negedge i_clk) begin
        if (hold_off) begin
            res_if.ready <= 0;
            if (hold_cycles == 0) hold_off <= 0;
            else hold_cycles <= hold_cycles - 1;
        end else if (ready_idle > 0) begin
            res_if.ready <= 0;
            ready_idle <= ready_idle - 1;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            res_if.ready <= 0;
            ready_idle <= $urandom_range(0, 2);
        end else begin
            res_if.ready <= 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            result_count++;
            if (hit_queue.size() == 0) begin
                report_mismatch("result with no query outstanding");
            end else begin
                if (res_if.hit !== hit_queue[0])
                    report_mismatch($sformatf("hit %b, predicted %b",
                                              res_if.hit, hit_queue[0]));
                if (hit_queue[0]) hit_seen++;
                void'(hit_queue.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 0;
        seg_if.valid    = 0;
        seg_if.start_x  = 0;
        seg_if.start_y  = 0;
        seg_if.end_x    = 0;
        seg_if.end_y    = 0;
        seg_if.center_x = 0;
        seg_if.center_y = 0;
        seg_if.radius_x = 1;
        seg_if.radius_y = 1;
        res_if.ready    = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;

        test_directed();
        test_random(250);
        test_output_stall();
        test_drain_pause();
        idle_enable = 0;
        test_random(280);

        seg_if.valid <= 0;
        while (hit_queue.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("covered %0d queries, %0d hits, extremes, tangents, stalls and drains",
                 result_count, hit_seen);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/sei_pkg.sv
sv/sei_in_if.sv
sv/sei_out_if.sv
sv/sei_prep.sv
sv/sei_coef.sv
sv/sei_decide.sv
sv/segment_ellipse_intersect_top.sv
verif/segment_ellipse_intersect_top_tb.sv
